// ===== sv/bbd_pkg.sv =====
// Shared types and constants of the BGGR bilinear demosaic block.
`timescale 1ns / 1ps

package bbd_pkg;

    localparam int PIXEL_W    = 8;
    localparam int CFG_W      = 12;
    localparam int OUT_DATA_W = 3 * PIXEL_W;

    // Configuration register indexes.
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    // Input item kinds carried on tuser.
    localparam logic MODE_RAW   = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    // Position of the output pixel, reduced to what the interpolation needs.
    typedef struct packed {
        logic odd_row;
        logic odd_col;
        logic row_gt0;
        logic col_gt0;
        logic row_lt_last;
        logic col_lt_last;
        logic frame_end;
    } emit_flags_t;

    // Control word of the item held in the read stage.
    typedef struct packed {
        logic        valid;
        logic        emit;
        logic        raw;
        logic        zero_top_mid;
        emit_flags_t flags;
    } stage_ctrl_t;

endpackage

// ===== sv/bbd_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module bbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/bbd_ctrl.sv =====
// Raster position tracking, drain sequencing and the line-store read stage.
`timescale 1ns / 1ps

module bbd_ctrl #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [bbd_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_accept,
    input  logic                           in_mode,
    input  logic [bbd_pkg::PIXEL_W-1:0]    in_pixel,
    input  logic                           stage_adv,
    output logic                           rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
    output bbd_pkg::stage_ctrl_t           stage_ctrl,
    output logic [bbd_pkg::PIXEL_W-1:0]    stage_pixel,
    output logic [$clog2(MAX_WIDTH)-1:0]   stage_addr
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WSZ_W  = $clog2(MAX_WIDTH + 1);
    localparam int HSZ_W  = $clog2(MAX_HEIGHT + 1);
    localparam int PEND_W = $clog2(MAX_WIDTH + 2);

    // Clamp a written size to 2..max and round it down to even.
    function automatic int eff_size(logic [bbd_pkg::CFG_W-1:0] v, int maxv);
        int t;
        t = int'(v);
        if (t < 2)
        begin
            t = 2;
        end
        if (t > maxv)
        begin
            t = maxv;
        end
        return t & ~1;
    endfunction

    localparam logic [WSZ_W-1:0] W_RESET =
        WSZ_W'(eff_size(bbd_pkg::FRAME_WIDTH_RESET, MAX_WIDTH));
    localparam logic [HSZ_W-1:0] H_RESET =
        HSZ_W'(eff_size(bbd_pkg::FRAME_HEIGHT_RESET, MAX_HEIGHT));

    logic [WSZ_W-1:0]  width_reg, width_next;
    logic [HSZ_W-1:0]  height_reg, height_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [PEND_W-1:0] pend_reg, pend_next;

    bbd_pkg::stage_ctrl_t        ctrl_reg, ctrl_next;
    logic [bbd_pkg::PIXEL_W-1:0] pixel_reg;
    logic [COL_W-1:0]            addr_reg;

    logic [WSZ_W-1:0]  w_m1;
    logic [HSZ_W-1:0]  h_m1;
    logic [COL_W-1:0]  cur_c;
    logic [ROW_W-1:0]  cur_r;
    logic [WSZ_W-1:0]  c_inc;
    logic [HSZ_W-1:0]  r_inc;
    logic              raw_valid;
    logic [PEND_W-1:0] w_p1;
    logic [PEND_W-1:0] k;
    logic              drain_ok;
    logic              item_used;
    logic [HSZ_W-1:0]  er;
    logic [WSZ_W-1:0]  ec;
    logic              is_raw;

    assign w_m1   = width_reg - WSZ_W'(1);
    assign h_m1   = height_reg - HSZ_W'(1);
    assign is_raw = (in_mode == bbd_pkg::MODE_RAW);
    assign w_p1   = PEND_W'(width_reg) + PEND_W'(1);
    assign k      = w_p1 - pend_reg;
    assign drain_ok  = (pend_reg != '0) && (pend_reg <= w_p1);
    assign item_used = is_raw || drain_ok;

    always_comb
    begin
        // A stale position outside the frame restarts at the origin.
        if ((WSZ_W'(col_reg) >= width_reg) || (HSZ_W'(row_reg) >= height_reg))
        begin
            cur_c = '0;
            cur_r = '0;
        end
        else
        begin
            cur_c = col_reg;
            cur_r = row_reg;
        end
        c_inc = WSZ_W'(cur_c) + WSZ_W'(1);
        r_inc = HSZ_W'(cur_r) + HSZ_W'(1);
        raw_valid = (cur_r >= ROW_W'(2)) || ((cur_r == ROW_W'(1)) && (cur_c != '0));

        if (is_raw)
        begin
            if (cur_c != '0)
            begin
                er = HSZ_W'(cur_r) - HSZ_W'(1);
                ec = WSZ_W'(cur_c) - WSZ_W'(1);
            end
            else
            begin
                er = HSZ_W'(cur_r) - HSZ_W'(2);
                ec = w_m1;
            end
        end
        else
        begin
            if (k == '0)
            begin
                er = height_reg - HSZ_W'(2);
                ec = w_m1;
            end
            else
            begin
                er = h_m1;
                ec = WSZ_W'(k - PEND_W'(1));
            end
        end
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        pend_next   = pend_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                bbd_pkg::CFG_FRAME_WIDTH:
                begin
                    width_next = WSZ_W'(eff_size(cfg_data, MAX_WIDTH));
                end
                bbd_pkg::CFG_FRAME_HEIGHT:
                begin
                    height_next = HSZ_W'(eff_size(cfg_data, MAX_HEIGHT));
                end
                default:
                begin
                    width_next = width_reg;
                end
            endcase
            col_next  = '0;
            row_next  = '0;
            pend_next = '0;
        end
        else if (in_accept)
        begin
            if (is_raw)
            begin
                pend_next = '0;
                if (c_inc >= width_reg)
                begin
                    col_next = '0;
                    if (r_inc >= height_reg)
                    begin
                        row_next  = '0;
                        pend_next = w_p1;
                    end
                    else
                    begin
                        row_next = r_inc[ROW_W-1:0];
                    end
                end
                else
                begin
                    col_next = c_inc[COL_W-1:0];
                    row_next = cur_r;
                end
            end
            else if (drain_ok)
            begin
                pend_next = pend_reg - PEND_W'(1);
            end
        end
    end

    always_comb
    begin
        ctrl_next = ctrl_reg;
        if (in_accept && item_used)
        begin
            ctrl_next.valid        = 1'b1;
            ctrl_next.raw          = is_raw;
            ctrl_next.emit         = is_raw ? raw_valid : 1'b1;
            ctrl_next.zero_top_mid = !is_raw && (k >= PEND_W'(width_reg));
            ctrl_next.flags.odd_row     = er[0];
            ctrl_next.flags.odd_col     = ec[0];
            ctrl_next.flags.row_gt0     = (er != '0);
            ctrl_next.flags.col_gt0     = (ec != '0);
            ctrl_next.flags.row_lt_last = (er != h_m1);
            ctrl_next.flags.col_lt_last = (ec != w_m1);
            ctrl_next.flags.frame_end   = (er == h_m1) && (ec == w_m1);
        end
        else if (stage_adv)
        begin
            ctrl_next.valid = 1'b0;
        end
    end

    assign rd_en   = in_accept && item_used;
    assign rd_addr = is_raw ? cur_c : k[COL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= W_RESET;
            height_reg <= H_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            pend_reg   <= '0;
            ctrl_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            pend_reg   <= pend_next;
            ctrl_reg   <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && item_used)
        begin
            pixel_reg <= is_raw ? in_pixel : '0;
            addr_reg  <= cur_c;
        end
    end

    assign stage_ctrl  = ctrl_reg;
    assign stage_pixel = pixel_reg;
    assign stage_addr  = addr_reg;

endmodule

// ===== sv/bbd_datapath.sv =====
// 3x3 window, bilinear interpolation and the result register.
`timescale 1ns / 1ps

module bbd_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bbd_pkg::stage_ctrl_t              stage_ctrl,
    input  logic [bbd_pkg::PIXEL_W-1:0]       stage_pixel,
    input  logic [bbd_pkg::PIXEL_W-1:0]       upper_rd,
    input  logic [bbd_pkg::PIXEL_W-1:0]       middle_rd,
    input  logic                              stage_adv,
    input  logic                              m_tready,
    output logic                              out_free,
    output logic                              m_tvalid,
    output logic [bbd_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);

    localparam int PW = bbd_pkg::PIXEL_W;

    logic [PW-1:0] win_reg  [3][3];
    logic [PW-1:0] win_next [3][3];
    logic [PW-1:0] col_top, col_mid;

    logic          out_valid_reg, out_valid_next;
    logic [PW-1:0] red_reg, green_reg, blue_reg;
    logic          last_reg;
    logic [PW-1:0] red, green, blue;
    logic          out_load;

    logic [PW+1:0] diag4, edge4;
    logic [PW:0]   rt_dn, dn_up, lf_rt, lf_up;

    assign col_top = stage_ctrl.zero_top_mid ? '0 : upper_rd;
    assign col_mid = stage_ctrl.zero_top_mid ? '0 : middle_rd;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = col_top;
        win_next[1][2] = col_mid;
        win_next[2][2] = stage_pixel;
    end

    // Neighbor sums on the window after this item's column has shifted in.
    always_comb
    begin
        diag4 = (PW+2)'(win_next[0][0]) + (PW+2)'(win_next[0][2])
              + (PW+2)'(win_next[2][0]) + (PW+2)'(win_next[2][2]);
        edge4 = (PW+2)'(win_next[1][0]) + (PW+2)'(win_next[1][2])
              + (PW+2)'(win_next[0][1]) + (PW+2)'(win_next[2][1]);
        rt_dn = (PW+1)'(win_next[1][2]) + (PW+1)'(win_next[2][1]);
        dn_up = (PW+1)'(win_next[2][1]) + (PW+1)'(win_next[0][1]);
        lf_rt = (PW+1)'(win_next[1][0]) + (PW+1)'(win_next[1][2]);
        lf_up = (PW+1)'(win_next[1][0]) + (PW+1)'(win_next[0][1]);
    end

    always_comb
    begin
        case ({stage_ctrl.flags.odd_row, stage_ctrl.flags.odd_col})
            2'b00:
            begin
                // Blue site.
                if (stage_ctrl.flags.row_gt0 && stage_ctrl.flags.col_gt0)
                begin
                    red   = diag4[PW+1:2];
                    green = edge4[PW+1:2];
                end
                else
                begin
                    red   = win_next[2][2];
                    green = rt_dn[PW:1];
                end
                blue = win_next[1][1];
            end
            2'b01:
            begin
                // Green site in a blue row.
                if (stage_ctrl.flags.row_gt0 && stage_ctrl.flags.col_lt_last)
                begin
                    red  = dn_up[PW:1];
                    blue = lf_rt[PW:1];
                end
                else
                begin
                    red  = win_next[2][1];
                    blue = win_next[1][0];
                end
                green = win_next[1][1];
            end
            2'b10:
            begin
                // Green site in a red row.
                if (stage_ctrl.flags.row_lt_last && stage_ctrl.flags.col_gt0)
                begin
                    red  = lf_rt[PW:1];
                    blue = dn_up[PW:1];
                end
                else
                begin
                    red  = win_next[1][2];
                    blue = win_next[0][1];
                end
                green = win_next[1][1];
            end
            default:
            begin
                // Red site.
                if (stage_ctrl.flags.row_lt_last && stage_ctrl.flags.col_lt_last)
                begin
                    green = edge4[PW+1:2];
                    blue  = diag4[PW+1:2];
                end
                else
                begin
                    green = lf_up[PW:1];
                    blue  = win_next[0][0];
                end
                red = win_next[1][1];
            end
        endcase
    end

    assign out_free = !out_valid_reg || m_tready;
    assign out_load = stage_adv && stage_ctrl.emit;

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (stage_adv)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            last_reg  <= stage_ctrl.flags.frame_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {blue_reg, green_reg, red_reg};
    assign m_tlast  = last_reg;

endmodule

// ===== sv/bayer_bggr_bilinear_demosaic.sv =====
// Top level of the streaming BGGR Bayer bilinear demosaic block.
`timescale 1ns / 1ps

// Usage:
// Raw 8-bit samples of a BGGR frame enter in raster order on the slave stream;
// tuser low marks a sample, tuser high a drain tick that flushes one pending
// pixel after the frame's last sample. Each transfer on the master stream is one
// red, green and blue triple, with tlast set on the bottom right pixel.
// The configuration port sets frame width (index 0) and height (index 1); any
// write restarts the frame and should be made while the block is idle.
// Throughput is one transfer per cycle on both sides while the master side does
// not stall. An accepted item reads both line stores into their registered
// outputs as it enters the read stage; the read data and the window then form
// the result combinationally, and the result register loads it when the read
// stage moves on. In pixel terms a result lags its sample by one row plus one
// pixel, so a frame needs width plus one drain ticks.
// A stall on the master side holds the result register; one more item can
// enter the read stage, and then tready on the slave side drops until the
// result is taken. Reset clears the window, position and drain counter and
// loads 640 by 480; the line stores are not cleared, as the stale entries read
// in the first row never reach a result.

module bayer_bggr_bilinear_demosaic #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [bbd_pkg::CFG_W-1:0]       cfg_data,
    // Slave stream. tdata: pixel[7:0]. tuser: mode[0].
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bbd_pkg::PIXEL_W-1:0]     s_tdata,
    input  logic                            s_tuser,
    // Master stream. tdata: red[7:0], green[15:8], blue[23:16]. tlast: frame_end.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bbd_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    bbd_pkg::stage_ctrl_t        stage_ctrl;
    logic [bbd_pkg::PIXEL_W-1:0] stage_pixel;
    logic [COL_W-1:0]            stage_addr;
    logic                        rd_en;
    logic [COL_W-1:0]            rd_addr;
    logic [bbd_pkg::PIXEL_W-1:0] upper_rd, middle_rd;
    logic                        out_free;
    logic                        stage_adv;
    logic                        in_accept;
    logic                        store_we;

    // The read stage moves on when its item needs no result slot or the
    // result register is free this cycle.
    assign stage_adv = stage_ctrl.valid && (!stage_ctrl.emit || out_free);
    assign s_tready  = !stage_ctrl.valid || stage_adv;
    assign in_accept = s_tvalid && s_tready;

    // A raw sample rolls its column down: the middle row moves up and the
    // new sample becomes the middle row.
    assign store_we = stage_adv && stage_ctrl.raw;

    bbd_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_accept   (in_accept),
        .in_mode     (s_tuser),
        .in_pixel    (s_tdata),
        .stage_adv   (stage_adv),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .stage_ctrl  (stage_ctrl),
        .stage_pixel (stage_pixel),
        .stage_addr  (stage_addr)
    );

    bbd_ram #(
        .WIDTH (bbd_pkg::PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (stage_addr),
        .wdata (middle_rd),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (upper_rd)
    );

    bbd_ram #(
        .WIDTH (bbd_pkg::PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (stage_addr),
        .wdata (stage_pixel),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (middle_rd)
    );

    bbd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_ctrl  (stage_ctrl),
        .stage_pixel (stage_pixel),
        .upper_rd    (upper_rd),
        .middle_rd   (middle_rd),
        .stage_adv   (stage_adv),
        .m_tready    (m_tready),
        .out_free    (out_free),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== sv/bbd_checker.sv =====
// Port-level assertions for the demosaic block and their bind to the top level.
`timescale 1ns / 1ps

module bbd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bbd_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                            m_tlast
);

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("result changed while stalled");

    // The input side only backs up behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a stalled result");

    // A fresh result comes from an input transfer that passed the read stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a matching input transfer");

    // No result is offered during reset.
    assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
    else $error("result offered during reset");

endmodule

bind bayer_bggr_bilinear_demosaic bbd_checker u_bbd_checker (.*);
